[src/pfs_pkg.sv]
package pfs_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_ENABLE = 3'd3,
        CMD_PERIOD = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_READ   = 3'd6,
        CMD_SEND   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DONE
    } state_t;

    localparam logic [4:0] SEND_NOW_SLOT = 5'd16;
    localparam int         MAX_EMIT      = 16;

    // One table entry as held by a cell
    typedef struct packed {
        logic [28:0] id;
        logic        ext;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [31:0] period;
        logic [31:0] stamp;
        logic        on;
    } entry_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic        clear;
        logic        take;
        logic        load;
        logic        set_on;
        logic        on_val;
        logic        set_per;
        logic [31:0] per_val;
        logic [31:0] stamp_val;
    } cell_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [4:0]  slot;
        logic [28:0] id;
        logic        ext;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [31:0] period;
        logic        active;
        logic [31:0] last_time;
        logic        last;
    } out_t;

endpackage

[src/pfs_cell.sv]
module pfs_cell
    import pfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctl,
    input  entry_t     nb,
    input  entry_t     new_entry,
    output entry_t     q
);

    entry_t entry_reg;
    entry_t entry_next;

    // Pick the cell's next content: wipe, take neighbour, load, or field update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            entry_next = '0;
        end
        else if (ctl.take)
        begin
            entry_next = nb;
        end
        else if (ctl.load)
        begin
            entry_next = new_entry;
        end
        else
        begin
            if (ctl.set_on)
            begin
                entry_next.on = ctl.on_val;
                if (ctl.on_val)
                begin
                    entry_next.stamp = ctl.stamp_val;
                end
            end
            if (ctl.set_per)
            begin
                entry_next.period = ctl.per_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

[src/periodic_frame_scheduler.sv]
// Periodic CAN frame scheduler. The table sits in a row of cells; tick and read
// rotate the row once through the head cell, one entry per clock (frames stream
// out one per cycle as due entries pass the head, then the status). Send now
// shows the frame, then the status; all other commands stay idle and show the
// status in the cycle after start. busy is high while a command is in
// work; results carry a one-cycle strobe and must be taken when shown.
module periodic_frame_scheduler
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] now_ms,
    input  logic [3:0]  slot_index,
    input  logic [28:0] msg_id,
    input  logic        msg_ext,
    input  logic [3:0]  msg_dlc,
    input  logic [63:0] msg_data,
    input  logic [31:0] period_ms,
    input  logic        enable,
    output logic        strobe,
    output logic        result_kind,
    output logic        ok,
    output logic [4:0]  slot_out,
    output logic [28:0] out_id,
    output logic        out_ext,
    output logic [3:0]  out_dlc,
    output logic [63:0] out_data,
    output logic [31:0] out_period,
    output logic        out_active,
    output logic [31:0] out_last_time,
    output logic        last_of_run
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [31:0]      now_reg, now_next;
    logic [3:0]       idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      time_reg, time_next;
    logic [4:0]       emit_reg, emit_next;
    entry_t           rd_reg, rd_next;
    out_t             out_reg, out_next;
    logic             strobe_reg, strobe_next;

    entry_t           cell_q [TABLE_DEPTH];
    cell_ctrl_t       cell_ctl [TABLE_DEPTH];
    entry_t           new_entry;
    entry_t           head_mod;
    logic             go;
    logic             idx_valid;
    logic             due;
    logic             ring_step;
    logic [7:0]       idx8;
    logic [7:0]       pos8;
    logic [7:0]       count8;

    assign busy   = (state_reg != ST_IDLE);
    assign go     = start && !busy;
    assign idx8   = {4'b0, slot_index};
    assign pos8   = 8'(pos_reg);
    assign count8 = 8'(count_reg);
    assign idx_valid = (idx8 < count8);
    assign ring_step = (state_reg == ST_ROTATE);

    // Build the new entry for add
    always_comb
    begin
        new_entry        = '0;
        new_entry.id     = msg_id;
        new_entry.ext    = msg_ext;
        new_entry.dlc    = msg_dlc;
        new_entry.data   = msg_data;
        new_entry.period = period_ms;
        new_entry.stamp  = time_reg;
        new_entry.on     = 1'b1;
    end

    // Check the head cell for a due frame and restamp it on its way round
    always_comb
    begin
        due = (cmd_reg == CMD_TICK) && (pos8 < count8) && cell_q[0].on
              && ((now_reg - cell_q[0].stamp) >= cell_q[0].period)
              && (32'(emit_reg) < MAX_EMIT);
        head_mod = cell_q[0];
        if (due)
        begin
            head_mod.stamp = now_reg;
        end
    end

    // Drive each cell
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t nb;
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign nb = head_mod;
            end
            else
            begin : g_mid
                assign nb = cell_q[gi + 1];
            end

            always_comb
            begin
                cell_ctl[gi]           = '0;
                cell_ctl[gi].clear     = go && (command == CMD_CLEAR);
                cell_ctl[gi].take      = ring_step
                    || (go && (command == CMD_REMOVE) && idx_valid
                        && (8'(gi) >= idx8) && (gi < TABLE_DEPTH - 1));
                cell_ctl[gi].load      = go && (command == CMD_ADD)
                    && (count8 < 8'(TABLE_DEPTH)) && (count8 == 8'(gi));
                cell_ctl[gi].set_on    = go && (command == CMD_ENABLE) && idx_valid
                    && (idx8 == 8'(gi));
                cell_ctl[gi].on_val    = enable;
                cell_ctl[gi].set_per   = go && (command == CMD_PERIOD) && idx_valid
                    && (idx8 == 8'(gi));
                cell_ctl[gi].per_val   = period_ms;
                cell_ctl[gi].stamp_val = time_reg;
            end

            pfs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl[gi]),
                .nb        (nb),
                .new_entry (new_entry),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    if ((command == CMD_TICK) || (command == CMD_READ))
                    begin
                        state_next = ST_ROTATE;
                    end
                    else if (command == CMD_SEND)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROTATE:
            begin
                if (pos8 == 8'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        cmd_next    = cmd_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        emit_next   = emit_reg;
        rd_next     = rd_reg;
        out_next    = '0;
        out_next.last = 1'b1;
        strobe_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    cmd_next   = cmd_t'(command);
                    now_next   = now_ms;
                    idx_next   = slot_index;
                    valid_next = idx_valid;
                    pos_next   = '0;
                    emit_next  = '0;
                    rd_next    = '0;
                    unique case (cmd_t'(command))
                        CMD_TICK:
                        begin
                            time_next = now_ms;
                        end
                        CMD_ADD:
                        begin
                            strobe_next = 1'b1;
                            if (count8 < 8'(TABLE_DEPTH))
                            begin
                                count_next  = count_reg + 1'b1;
                                out_next.ok = 1'b1;
                                out_next.slot = 5'(count_reg);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            strobe_next = 1'b1;
                            out_next.ok = idx_valid;
                            if (idx_valid)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_ENABLE, CMD_PERIOD:
                        begin
                            strobe_next = 1'b1;
                            out_next.ok = idx_valid;
                        end
                        CMD_CLEAR:
                        begin
                            strobe_next = 1'b1;
                            out_next.ok = 1'b1;
                            time_next   = now_ms;
                            count_next  = '0;
                        end
                        CMD_READ:
                        begin
                        end
                        CMD_SEND:
                        begin
                            strobe_next   = 1'b1;
                            out_next.kind = 1'b1;
                            out_next.ok   = 1'b1;
                            out_next.slot = SEND_NOW_SLOT;
                            out_next.id   = msg_id;
                            out_next.ext  = msg_ext;
                            out_next.dlc  = msg_dlc;
                            out_next.data = msg_data;
                            out_next.last = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ROTATE:
            begin
                pos_next = pos_reg + 1'b1;
                if (due)
                begin
                    emit_next     = emit_reg + 1'b1;
                    strobe_next   = 1'b1;
                    out_next.kind = 1'b1;
                    out_next.ok   = 1'b1;
                    out_next.slot = 5'(pos_reg);
                    out_next.id   = cell_q[0].id;
                    out_next.ext  = cell_q[0].ext;
                    out_next.dlc  = cell_q[0].dlc;
                    out_next.data = cell_q[0].data;
                    out_next.last = 1'b0;
                end
                if ((cmd_reg == CMD_READ) && ({4'b0, idx_reg} == pos8))
                begin
                    rd_next = cell_q[0];
                end
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                out_next.ok = 1'b1;
                if (cmd_reg == CMD_READ)
                begin
                    out_next.ok = valid_reg;
                    if (valid_reg)
                    begin
                        out_next.slot      = {1'b0, idx_reg};
                        out_next.id        = rd_reg.id;
                        out_next.ext       = rd_reg.ext;
                        out_next.dlc       = rd_reg.dlc;
                        out_next.data      = rd_reg.data;
                        out_next.period    = rd_reg.period;
                        out_next.active    = rd_reg.on;
                        out_next.last_time = rd_reg.stamp;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            time_reg   <= '0;
            strobe_reg <= 1'b0;
            pos_reg    <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            time_reg   <= time_next;
            strobe_reg <= strobe_next;
            pos_reg    <= pos_next;
            emit_reg   <= emit_next;
        end
    end

    // Hold the command and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        now_reg   <= now_next;
        idx_reg   <= idx_next;
        valid_reg <= valid_next;
        rd_reg    <= rd_next;
        out_reg   <= out_next;
    end

    assign strobe        = strobe_reg;
    assign result_kind   = out_reg.kind;
    assign ok            = out_reg.ok;
    assign slot_out      = out_reg.slot;
    assign out_id        = out_reg.id;
    assign out_ext       = out_reg.ext;
    assign out_dlc       = out_reg.dlc;
    assign out_data      = out_reg.data;
    assign out_period    = out_reg.period;
    assign out_active    = out_reg.active;
    assign out_last_time = out_reg.last_time;
    assign last_of_run   = out_reg.last;

    // A frame transaction never closes a command
    a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result_kind) |-> !last_of_run)
        else $error("frame transaction marked last");

    // Leaving the busy state always shows its status
    a_status_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last_of_run))
        else $error("no status when command finished");

    // Entry count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count8 <= 8'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Emissions per tick stay within the cap
    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(emit_reg) <= MAX_EMIT)
        else $error("emission cap exceeded");

endmodule
